// ===== design/urbc_pkg.sv =====
package urbc_pkg;

    // mode codes
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_OFFLINE  = 3'd1;
    localparam logic [2:0] MODE_SENDING  = 3'd2;
    localparam logic [2:0] MODE_BACKOFF  = 3'd3;
    localparam logic [2:0] MODE_DISABLED = 3'd4;

    // disposition codes
    localparam logic [1:0] DISP_NONE   = 2'd0;
    localparam logic [1:0] DISP_DELETE = 2'd1;
    localparam logic [1:0] DISP_FAILED = 2'd2;
    localparam logic [1:0] DISP_RETRY  = 2'd3;

    // item kinds
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    // register indexes
    localparam logic [1:0] CFG_ENABLED     = 2'd0;
    localparam logic [1:0] CFG_BASE        = 2'd1;
    localparam logic [1:0] CFG_CAP         = 2'd2;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd3;

    // register reset values
    localparam logic        ENABLED_RESET     = 1'b1;
    localparam logic [31:0] BASE_RESET        = 32'd1000;
    localparam logic [31:0] CAP_RESET         = 32'd60000;
    localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd5;

    // result code classes
    localparam logic signed [15:0] CODE_OK_LO   = 16'sd200;
    localparam logic signed [15:0] CODE_OK_HI   = 16'sd300;
    localparam logic signed [15:0] CODE_4XX_LO  = 16'sd400;
    localparam logic signed [15:0] CODE_4XX_HI  = 16'sd500;
    localparam logic signed [15:0] CODE_UNAUTH  = 16'sd401;
    localparam logic signed [15:0] CODE_TIMEOUT = 16'sd408;
    localparam logic signed [15:0] CODE_THROTTLE = 16'sd429;

    localparam logic [7:0] RETRY_MAX = 8'hFF;

    typedef struct packed {
        logic               action;
        logic               link_up;
        logic [31:0]        now_ms;
        logic               queue_has_item;
        logic [31:0]        segment_id;
        logic signed [15:0] result_code;
        logic [31:0]        segment_bytes;
    } t_in;

    typedef struct packed {
        logic [2:0]         mode;
        logic               start_upload;
        logic [1:0]         disposition;
        logic [7:0]         retries;
        logic [31:0]        backoff_now_ms;
        logic [31:0]        ok_count;
        logic [31:0]        failed_count;
        logic [31:0]        bytes_sent;
        logic signed [15:0] last_code;
    } t_out;

    typedef struct packed {
        logic        enabled;
        logic [31:0] base_backoff_ms;
        logic [31:0] backoff_cap_ms;
        logic [7:0]  retry_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        backoff;
        logic [31:0]        deadline;
        logic [7:0]         retry_cnt;
        logic [31:0]        tracked_seg;
        logic               tracked_valid;
        logic [31:0]        ok_total;
        logic [31:0]        failed_total;
        logic [31:0]        byte_total;
        logic signed [15:0] code;
    } t_state;

endpackage

// ===== design/urbc_cfg.sv =====
module urbc_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_wdata,
    output urbc_pkg::t_cfg   o_cfg
);
    import urbc_pkg::*;

    t_cfg r_cfg;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled         <= ENABLED_RESET;
            r_cfg.base_backoff_ms <= BASE_RESET;
            r_cfg.backoff_cap_ms  <= CAP_RESET;
            r_cfg.retry_limit     <= RETRY_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLED:     r_cfg.enabled         <= i_cfg_wdata[0];
                CFG_BASE:        r_cfg.base_backoff_ms <= i_cfg_wdata;
                CFG_CAP:         r_cfg.backoff_cap_ms  <= i_cfg_wdata;
                CFG_RETRY_LIMIT: r_cfg.retry_limit     <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/urbc_step.sv =====
module urbc_step (
    input  urbc_pkg::t_state i_state,
    input  urbc_pkg::t_cfg   i_cfg,
    input  urbc_pkg::t_in    i_item,
    output urbc_pkg::t_state o_state,
    output urbc_pkg::t_out   o_result
);
    import urbc_pkg::*;

    logic        w_waiting;
    logic        w_new_seg;
    logic        w_ok;
    logic        w_permanent;
    logic [7:0]  w_retry_inc;
    logic [32:0] w_grown;
    logic [31:0] w_backoff_next;
    logic [31:0] w_elapsed;
    logic        w_start;
    logic [1:0]  w_disp;
    t_state      w_st;

    // deadline still ahead when wrapped difference has its top bit set
    assign w_elapsed = i_item.now_ms - i_state.deadline;
    assign w_waiting = (i_state.mode == MODE_BACKOFF) && w_elapsed[31];
    assign w_new_seg = !i_state.tracked_valid ||
                       (i_state.tracked_seg != i_item.segment_id);

    // code classification
    assign w_ok = (i_item.result_code >= CODE_OK_LO) && (i_item.result_code < CODE_OK_HI);
    assign w_permanent = (i_item.result_code >= CODE_4XX_LO) &&
                         (i_item.result_code < CODE_4XX_HI) &&
                         (i_item.result_code != CODE_UNAUTH) &&
                         (i_item.result_code != CODE_TIMEOUT) &&
                         (i_item.result_code != CODE_THROTTLE);
    assign w_retry_inc = (i_state.retry_cnt == RETRY_MAX) ? RETRY_MAX
                                                          : i_state.retry_cnt + 8'd1;

    // capped doubling, zero restarts from base
    assign w_grown = (i_state.backoff == 32'd0) ? {1'b0, i_cfg.base_backoff_ms}
                                                : {i_state.backoff, 1'b0};
    assign w_backoff_next = (w_grown > {1'b0, i_cfg.backoff_cap_ms}) ? i_cfg.backoff_cap_ms
                                                                    : w_grown[31:0];

    // next state
    always_comb begin
        w_st    = i_state;
        w_start = 1'b0;
        w_disp  = DISP_NONE;
        if (i_cfg.enabled) begin
            if (i_item.action == ACT_TICK) begin
                if (i_state.mode == MODE_SENDING) begin
                    w_st = i_state;
                end else if (!i_item.link_up) begin
                    w_st.mode = MODE_OFFLINE;
                end else if (w_waiting) begin
                    w_st = i_state;
                end else if (!i_item.queue_has_item) begin
                    w_st.mode = MODE_IDLE;
                end else begin
                    if (w_new_seg) begin
                        w_st.tracked_seg   = i_item.segment_id;
                        w_st.tracked_valid = 1'b1;
                        w_st.retry_cnt     = 8'd0;
                        w_st.backoff       = i_cfg.base_backoff_ms;
                    end
                    w_st.mode = MODE_SENDING;
                    w_start   = 1'b1;
                end
            end else if (i_state.mode == MODE_SENDING) begin
                w_st.code = i_item.result_code;
                if (w_ok) begin
                    w_st.ok_total      = i_state.ok_total + 32'd1;
                    w_st.byte_total    = i_state.byte_total + i_item.segment_bytes;
                    w_st.retry_cnt     = 8'd0;
                    w_st.tracked_valid = 1'b0;
                    w_st.backoff       = i_cfg.base_backoff_ms;
                    w_st.mode          = MODE_IDLE;
                    w_disp             = DISP_DELETE;
                end else if (w_permanent || (w_retry_inc >= i_cfg.retry_limit)) begin
                    w_st.failed_total  = i_state.failed_total + 32'd1;
                    w_st.retry_cnt     = 8'd0;
                    w_st.tracked_valid = 1'b0;
                    w_st.backoff       = i_cfg.base_backoff_ms;
                    w_st.mode          = MODE_IDLE;
                    w_disp             = DISP_FAILED;
                end else begin
                    w_st.retry_cnt = w_retry_inc;
                    w_st.backoff   = w_backoff_next;
                    w_st.deadline  = i_item.now_ms + w_backoff_next;
                    w_st.mode      = MODE_BACKOFF;
                    w_disp         = DISP_RETRY;
                end
            end
        end
    end

    assign o_state = w_st;

    // result fields from the updated state
    always_comb begin
        o_result.mode           = i_cfg.enabled ? w_st.mode : MODE_DISABLED;
        o_result.start_upload   = w_start;
        o_result.disposition    = w_disp;
        o_result.retries        = w_st.retry_cnt;
        o_result.backoff_now_ms = w_st.backoff;
        o_result.ok_count       = w_st.ok_total;
        o_result.failed_count   = w_st.failed_total;
        o_result.bytes_sent     = w_st.byte_total;
        o_result.last_code      = w_st.code;
    end

endmodule

// ===== design/upload_retry_backoff_controller.sv =====
// Upload retry controller with capped exponential backoff. Each input transaction is a tick
// or an attempt report and yields exactly one result transaction. A transaction is captured
// in an input register, evaluated against the state registers by one pass of compare, add and
// shift logic, and written to a result register; one transaction is accepted every cycle
// unless the result side stalls, the result register parting the two handshakes. Configuration
// writes take effect on the next cycle and should be made while no transaction is in flight.
module upload_retry_backoff_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  urbc_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output urbc_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_wdata
);
    import urbc_pkg::*;

    t_cfg   w_cfg;
    t_in    r_in;
    logic   r_in_valid;
    t_state r_state;
    t_state n_state;
    t_out   n_res;
    t_out   r_out;
    logic   r_out_valid;
    logic   w_adv;

    urbc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    urbc_step u_step (
        .i_state  (r_state),
        .i_cfg    (w_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // input stage moves on when the result register is free or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode          <= MODE_IDLE;
            r_state.backoff       <= BASE_RESET;
            r_state.deadline      <= 32'd0;
            r_state.retry_cnt     <= 8'd0;
            r_state.tracked_seg   <= 32'd0;
            r_state.tracked_valid <= 1'b0;
            r_state.ok_total      <= 32'd0;
            r_state.failed_total  <= 32'd0;
            r_state.byte_total    <= 32'd0;
            r_state.code          <= 16'sd0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // an upload request always leaves the block sending
    a_start_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.start_upload |-> o_out_data.mode == MODE_SENDING)
        else $error("start_upload without sending mode");

    // a retry always leaves the block in backoff
    a_retry_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.disposition == DISP_RETRY)
        |-> o_out_data.mode == MODE_BACKOFF)
        else $error("retry disposition without backoff mode");

    // a delete bumps the success total by one
    a_delete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (n_res.disposition == DISP_DELETE)
        |=> r_state.ok_total == $past(r_state.ok_total) + 32'd1)
        else $error("success total not advanced on delete");

    // a held transaction is not lost while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in))
        else $error("input register dropped while stalled");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import urbc_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_LIMIT = 10;
    localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_ENABLED;
    logic [31:0] i_cfg_wdata = '0;

    // shadow of the configuration registers
    logic        cfg_enabled = ENABLED_RESET;
    logic [31:0] cfg_base = BASE_RESET;
    logic [31:0] cfg_cap = CAP_RESET;
    logic [7:0]  cfg_limit = RETRY_LIMIT_RESET;

    // shadow of the controller state
    logic [2:0]         ctl_mode = MODE_IDLE;
    logic [31:0]        ctl_backoff = BASE_RESET;
    logic [31:0]        ctl_deadline = '0;
    logic [7:0]         ctl_retries = '0;
    logic [31:0]        ctl_seg = '0;
    logic               ctl_seg_valid = 1'b0;
    logic [31:0]        ctl_ok = '0;
    logic [31:0]        ctl_failed = '0;
    logic [31:0]        ctl_bytes = '0;
    logic signed [15:0] ctl_code = '0;

    t_out expected_results[$];

    // bookkeeping
    int accepted_items = 0;
    int checked_results = 0;
    int mismatches = 0;
    int input_stalls = 0;
    int delivered = 0;
    int given_up = 0;
    int rescheduled = 0;

    // traffic shaping
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          receiver_hold = 0;
    int          quiet_cycles = 0;
    logic [31:0] wall_ms = '0;
    logic [31:0] cur_seg = 32'h100;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    upload_retry_backoff_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // segment finished, back to base backoff
    function automatic void restart_tracking();
        ctl_retries = '0;
        ctl_seg_valid = 1'b0;
        ctl_backoff = cfg_base;
        ctl_mode = MODE_IDLE;
    endfunction

    // next result of the controller for one accepted transaction
    function automatic t_out predict_upload_result(t_in item);
        t_out        res;
        logic [32:0] grown;
        logic [31:0] ahead;
        logic        permanent;
        res = '0;
        ahead = item.now_ms - ctl_deadline;
        if (cfg_enabled) begin
            if (item.action == ACT_TICK) begin
                if (ctl_mode == MODE_SENDING) begin
                    // tick while an upload is outstanding
                end else if (!item.link_up) begin
                    ctl_mode = MODE_OFFLINE;
                end else if (ctl_mode == MODE_BACKOFF && ahead > HALF_RANGE) begin
                    // deadline still ahead
                end else if (!item.queue_has_item) begin
                    ctl_mode = MODE_IDLE;
                end else begin
                    if (!ctl_seg_valid || ctl_seg != item.segment_id) begin
                        ctl_seg = item.segment_id;
                        ctl_seg_valid = 1'b1;
                        ctl_retries = '0;
                        ctl_backoff = cfg_base;
                    end
                    ctl_mode = MODE_SENDING;
                    res.start_upload = 1'b1;
                end
            end else if (ctl_mode == MODE_SENDING) begin
                ctl_code = item.result_code;
                if (item.result_code >= CODE_OK_LO && item.result_code < CODE_OK_HI) begin
                    ctl_ok = ctl_ok + 32'd1;
                    ctl_bytes = ctl_bytes + item.segment_bytes;
                    restart_tracking();
                    res.disposition = DISP_DELETE;
                end else begin
                    permanent = item.result_code >= CODE_4XX_LO &&
                                item.result_code < CODE_4XX_HI &&
                                item.result_code != CODE_UNAUTH &&
                                item.result_code != CODE_TIMEOUT &&
                                item.result_code != CODE_THROTTLE;
                    if (ctl_retries != RETRY_MAX) begin
                        ctl_retries = ctl_retries + 8'd1;
                    end
                    if (permanent || ctl_retries >= cfg_limit) begin
                        ctl_failed = ctl_failed + 32'd1;
                        restart_tracking();
                        res.disposition = DISP_FAILED;
                    end else begin
                        // doubling without wrap, zero reloads the base
                        if (ctl_backoff == '0) begin
                            grown = {1'b0, cfg_base};
                        end else begin
                            grown = {ctl_backoff, 1'b0};
                        end
                        if (grown > {1'b0, cfg_cap}) begin
                            grown = {1'b0, cfg_cap};
                        end
                        ctl_backoff = grown[31:0];
                        ctl_deadline = item.now_ms + ctl_backoff;
                        ctl_mode = MODE_BACKOFF;
                        res.disposition = DISP_RETRY;
                    end
                end
            end
            res.mode = ctl_mode;
        end else begin
            res.mode = MODE_DISABLED;
        end
        res.retries = ctl_retries;
        res.backoff_now_ms = ctl_backoff;
        res.ok_count = ctl_ok;
        res.failed_count = ctl_failed;
        res.bytes_sent = ctl_bytes;
        res.last_code = ctl_code;
        return res;
    endfunction

    function automatic string describe(t_out r);
        return $sformatf({"mode=%0d start=%0d disp=%0d retries=%0d backoff=%0d ",
                          "ok=%0d failed=%0d bytes=%0d code=%0d"},
                         r.mode, r.start_upload, r.disposition, r.retries,
                         r.backoff_now_ms, r.ok_count, r.failed_count, r.bytes_sent,
                         r.last_code);
    endfunction

    // compare one result transaction with the oldest pending expectation
    function automatic void compare_upload_result(t_out got);
        t_out  want;
        string bad;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("result with nothing pending: %s", describe(got));
            end
            return;
        end
        want = expected_results.pop_front();
        checked_results++;
        case (want.disposition)
            DISP_DELETE: begin
                delivered++;
            end
            DISP_FAILED: begin
                given_up++;
            end
            DISP_RETRY: begin
                rescheduled++;
            end
            default: begin
            end
        endcase
        bad = "";
        if (got.mode !== want.mode) bad = {bad, " mode"};
        if (got.start_upload !== want.start_upload) bad = {bad, " start_upload"};
        if (got.disposition !== want.disposition) bad = {bad, " disposition"};
        if (got.retries !== want.retries) bad = {bad, " retries"};
        if (got.backoff_now_ms !== want.backoff_now_ms) bad = {bad, " backoff_now_ms"};
        if (got.ok_count !== want.ok_count) bad = {bad, " ok_count"};
        if (got.failed_count !== want.failed_count) bad = {bad, " failed_count"};
        if (got.bytes_sent !== want.bytes_sent) bad = {bad, " bytes_sent"};
        if (got.last_code !== want.last_code) bad = {bad, " last_code"};
        if (bad != "") begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("result %0d differs in%s", checked_results, bad);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        end
    endfunction

    // both handshakes, sampled before the edge updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                compare_upload_result(o_out_data);
            end
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_upload_result(i_in_data));
                accepted_items++;
            end else if (i_in_valid) begin
                input_stalls++;
            end
        end
    end

    // result side ready, with random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (receiver_hold > 0) begin
            i_out_ready = 1'b0;
            receiver_hold--;
        end else begin
            i_out_ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("timeout after %0d quiet cycles", QUIET_LIMIT);
        $display("FAIL upload_retry_backoff_controller");
        $finish;
    end

    function automatic t_in random_fields();
        t_in item;
        item.action = 1'($urandom);
        item.link_up = 1'($urandom);
        item.now_ms = $urandom;
        item.queue_has_item = 1'($urandom);
        item.segment_id = $urandom;
        item.result_code = 16'($urandom);
        item.segment_bytes = $urandom;
        return item;
    endfunction

    // offer one transaction and hold it until accepted, called at a falling edge
    task automatic send_item(input t_in item);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_data = item;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_tick(input logic link, input logic [31:0] now,
                             input logic queued, input logic [31:0] seg);
        t_in item;
        item = random_fields();
        item.action = ACT_TICK;
        item.link_up = link;
        item.now_ms = now;
        item.queue_has_item = queued;
        item.segment_id = seg;
        send_item(item);
    endtask

    task automatic send_report(input logic signed [15:0] code, input logic [31:0] now,
                               input logic [31:0] nbytes);
        t_in item;
        item = random_fields();
        item.action = ACT_REPORT;
        item.result_code = code;
        item.now_ms = now;
        item.segment_bytes = nbytes;
        send_item(item);
    endtask

    // stop offering and let every pending result come back
    task automatic wait_for_drain();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] reg_index, input logic [31:0] value);
        wait_for_drain();
        i_cfg_we = 1'b1;
        i_cfg_index = reg_index;
        i_cfg_wdata = value;
        case (reg_index)
            CFG_ENABLED: begin
                cfg_enabled = value[0];
            end
            CFG_BASE: begin
                cfg_base = value;
            end
            CFG_CAP: begin
                cfg_cap = value;
            end
            default: begin
                cfg_limit = value[7:0];
            end
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // time for the next transaction, often landing near the deadline
    function automatic logic [31:0] pick_now();
        int unsigned r;
        r = $urandom_range(19);
        if (r < 8) begin
            wall_ms = wall_ms + $urandom_range(3000);
        end else if (r < 13) begin
            wall_ms = ctl_deadline + $urandom_range(4) - 32'd2;
        end else if (r < 17) begin
            wall_ms = wall_ms + $urandom_range(32'h000F_FFFF);
        end else begin
            wall_ms = $urandom;
        end
        return wall_ms;
    endfunction

    function automatic logic signed [15:0] pick_code();
        int unsigned r;
        logic [31:0] pick;
        r = $urandom_range(99);
        if (r < 35) begin
            pick = $urandom_range(299, 200);
        end else if (r < 50) begin
            pick = $urandom_range(499, 400);
        end else if (r < 62) begin
            case ($urandom_range(2))
                0: pick = 32'(CODE_UNAUTH);
                1: pick = 32'(CODE_TIMEOUT);
                default: pick = 32'(CODE_THROTTLE);
            endcase
        end else if (r < 82) begin
            pick = $urandom_range(599, 500);
        end else if (r < 92) begin
            pick = 32'd0 - $urandom_range(32768, 1);
        end else begin
            pick = $urandom;
        end
        return pick[15:0];
    endfunction

    function automatic logic [31:0] pick_backoff();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return ALL_ONES;
            3: return $urandom;
            4, 5: return $urandom_range(200000, 5000);
            default: return $urandom_range(5000, 100);
        endcase
    endfunction

    task automatic randomize_registers();
        int unsigned r;
        r = $urandom_range(99);
        write_register(CFG_ENABLED, 32'd1);
        write_register(CFG_BASE, pick_backoff());
        write_register(CFG_CAP, pick_backoff());
        if (r < 10) begin
            write_register(CFG_RETRY_LIMIT, 32'd0);
        end else if (r < 20) begin
            write_register(CFG_RETRY_LIMIT, 32'd255);
        end else if (r < 30) begin
            write_register(CFG_RETRY_LIMIT, 32'd1);
        end else begin
            write_register(CFG_RETRY_LIMIT, $urandom_range(8, 2));
        end
    endtask

    // stray or malformed transactions mixed into the traffic
    task automatic send_noise();
        case ($urandom_range(3))
            0: begin
                send_item(random_fields());
            end
            1: begin
                send_tick(1'b0, pick_now(), 1'($urandom), $urandom);
            end
            2: begin
                send_tick(1'b1, pick_now(), 1'b0, $urandom);
            end
            default: begin
                send_report(pick_code(), pick_now(), $urandom);
            end
        endcase
    endtask

    // upload cycles driven by the current controller mode
    task automatic run_traffic(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 12) begin
                send_noise();
            end else if (ctl_mode == MODE_SENDING) begin
                send_report(pick_code(), pick_now(), $urandom);
                sent++;
            end else begin
                if ((!ctl_seg_valid && $urandom_range(99) < 70) ||
                    $urandom_range(99) < 4) begin
                    cur_seg = $urandom_range(1) ? $urandom : $urandom_range(7);
                end
                send_tick(1'b1, pick_now(), 1'b1, cur_seg);
                sent++;
            end
        end
    endtask

    // mode walk: offline, idle, send, ignored items, wrapped deadline, permanent failure
    task automatic test_tick_and_report_flow();
        send_tick(1'b0, '0, 1'b1, '0);
        send_report(16'sd200, '0, '0);
        send_tick(1'b1, '0, 1'b0, '0);
        send_tick(1'b1, '0, 1'b1, '0);
        send_tick(1'b1, '0, 1'b1, '0);
        send_report(16'sd200, '0, ALL_ONES);
        send_tick(1'b1, 32'hFFFF_FFF0, 1'b1, ALL_ONES);
        send_report(16'sd503, 32'hFFFF_FFF0, '0);
        send_tick(1'b1, 32'h0000_0100, 1'b1, ALL_ONES);
        send_report(16'sd200, 32'h0000_0100, '0);
        send_tick(1'b1, 32'h0000_07C0, 1'b1, ALL_ONES);
        send_report(16'sd401, 32'h0000_07C0, '0);
        send_tick(1'b0, 32'h0000_0800, 1'b1, ALL_ONES);
        send_tick(1'b1, 32'h0000_0800, 1'b1, ALL_ONES);
        send_report(16'sd404, 32'h0000_0800, '0);
    endtask

    // boundaries of the code classes on one segment
    task automatic test_result_code_classes();
        logic signed [15:0] codes [7];
        codes = '{16'sd408, 16'sd429, 16'sd499, 16'sh8000, 16'sh7FFF, 16'sd199, 16'sd300};
        wall_ms = 32'h0010_0000;
        foreach (codes[k]) begin
            wall_ms = wall_ms + 32'd100000;
            send_tick(1'b1, wall_ms, 1'b1, 32'h7);
            send_report(codes[k], wall_ms, $urandom);
        end
    endtask

    // retry limit zero, zero backoff, saturation at a full-range cap
    task automatic test_backoff_limits();
        write_register(CFG_RETRY_LIMIT, 32'd0);
        wall_ms = wall_ms + 32'd100000;
        send_tick(1'b1, wall_ms, 1'b1, 32'h1000);
        send_report(16'sd503, wall_ms, '0);
        write_register(CFG_RETRY_LIMIT, 32'd255);
        write_register(CFG_CAP, '0);
        send_tick(1'b1, wall_ms, 1'b1, 32'h2000);
        send_report(16'sd503, wall_ms, '0);
        write_register(CFG_CAP, ALL_ONES);
        send_tick(1'b1, wall_ms, 1'b1, 32'h2000);
        send_report(16'sd503, wall_ms, '0);
        write_register(CFG_BASE, ALL_ONES);
        send_tick(1'b1, wall_ms, 1'b1, 32'h3000);
        send_report(16'sd503, wall_ms, '0);
        send_tick(1'b1, wall_ms, 1'b1, 32'h3000);
        send_report(16'sd200, wall_ms, '0);
        write_register(CFG_BASE, BASE_RESET);
        write_register(CFG_CAP, CAP_RESET);
        write_register(CFG_RETRY_LIMIT, 32'(RETRY_LIMIT_RESET));
    endtask

    // disabled block holds its state and resumes
    task automatic test_disable_hold();
        write_register(CFG_ENABLED, 32'd0);
        wall_ms = wall_ms + 32'd100000;
        send_tick(1'b1, wall_ms, 1'b1, 32'h5000);
        send_report(16'sd200, wall_ms, $urandom);
        write_register(CFG_ENABLED, 32'd1);
        send_tick(1'b1, wall_ms, 1'b1, 32'h5000);
        send_report(16'sd500, wall_ms, $urandom);
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_stall();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        receiver_hold = 120;
        run_traffic(40);
    endtask

    // sender waits for every result before going on
    task automatic test_sender_pause();
        run_traffic(15);
        wait_for_drain();
        run_traffic(15);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (2) begin
            randomize_registers();
            run_traffic(count / 2);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_tick_and_report_flow();
        test_result_code_classes();
        test_backoff_limits();
        test_disable_hold();
        test_output_stall();
        test_sender_pause();
        test_random_traffic(0, 0, 270);
        test_random_traffic(77, 0, 270);
        test_random_traffic(0, 77, 270);
        test_random_traffic(16, 16, 270);

        wait_for_drain();
        $display("covered %0d transactions in and %0d results out:",
                 accepted_items, checked_results);
        $display("  %0d delivered, %0d given up, %0d retried, input held off on %0d cycles",
                 delivered, given_up, rescheduled, input_stalls);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS upload_retry_backoff_controller");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL upload_retry_backoff_controller");
        end
        $finish;
    end

endmodule
